/* sv/ils_pkg.sv */
// Shared types and codes for the indexed list store.
// No dependencies; used by indexed_list_store.

package ils_pkg;

	typedef enum logic [2:0] {
		CMD_PUSH   = 3'd0,
		CMD_POP    = 3'd1,
		CMD_INSERT = 3'd2,
		CMD_DELETE = 3'd3,
		CMD_FIND   = 3'd4,
		CMD_REMOVE = 3'd5,
		CMD_READ   = 3'd6,
		CMD_NOP    = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		STS_OK       = 3'd0,
		STS_RANGE    = 3'd1,
		STS_FULL     = 3'd2,
		STS_EMPTY    = 3'd3,
		STS_NOTFOUND = 3'd4
	} status_t;

	localparam int WORD_W = 32;
	localparam int EXT_W  = 32;

endpackage

/* sv/indexed_list_store.sv */
// Indexed list store: ordered store of up to DEPTH signed words with fill count.
// Depends on ils_pkg and ils_ram.
//
// The words live in one RAM with a registered read. Push, requests that fail their
// checks, an insert at the count, a delete of the last entry, find or remove all on
// an empty store and the unused code pass from acceptance directly to the response
// state. Pop and read fetch their one entry through the read port first. Insert,
// delete, find and remove all sweep the RAM one entry a cycle through its single
// read port, with the shifted or compacted word written back in the cycle after its
// read is issued. The entries swept are those at and above the index for insert,
// those above it for delete, and all stored entries for find and remove all. A new
// request is accepted while the previous response still waits to be taken.

module indexed_list_store #(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [2:0]  cmd,
	input  logic [4:0]  index,
	input  logic signed [31:0] value,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [2:0]  status,
	output logic signed [31:0] data,
	output logic [3:0]  position,
	output logic [4:0]  removed_count,
	output logic [4:0]  fill_count,
	output logic        empty_res
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = ils_pkg::EXT_W;
	localparam int DW = ils_pkg::WORD_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESP
	} state_t;

	state_t             state_q;
	ils_pkg::cmd_t      cmd_q;
	ils_pkg::status_t   res_status_q;
	logic [DW-1:0]      val_q;
	logic [DW-1:0]      res_data_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      rem_q;
	logic [AW-1:0]      ptr_q;
	logic [AW-1:0]      lim_q;
	logic [AW-1:0]      idx_q;
	logic [AW-1:0]      wptr_q;
	logic [AW-1:0]      pos_q;
	logic               rd_on_q;
	logic               hit_q;
	logic               s1_v_s1;
	logic [AW-1:0]      s1_addr_s1;

	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [DW-1:0]      ram_wdata;
	logic [DW-1:0]      ram_rdata;

	ils_pkg::cmd_t      cmd_in;
	logic [XW-1:0]      idx_x;
	logic [XW-1:0]      cnt_x;
	logic [XW-1:0]      pos_x;
	logic [XW-1:0]      rem_x;
	logic [XW-1:0]      cnt_nx;
	logic [CW-1:0]      cnt_m1;
	logic               full;
	logic               accept;
	logic               append;
	logic               match;
	logic               done;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign cmd_in    = ils_pkg::cmd_t'(cmd);
	assign idx_x     = XW'(index);
	assign cnt_x     = XW'(count_q);
	assign cnt_m1    = count_q - CW'(1);
	assign full      = (count_q == CW'(DEPTH));
	assign append    = accept && !full && ((cmd_in == ils_pkg::CMD_PUSH) ||
		((cmd_in == ils_pkg::CMD_INSERT) && (idx_x == cnt_x)));
	assign match     = (ram_rdata == val_q);
	assign done      = !rd_on_q && !s1_v_s1;
	assign pos_x     = XW'(pos_q);
	assign rem_x     = XW'(rem_q);
	assign cnt_nx    = XW'(count_q);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[AW-1:0];
		ram_wdata = value;
		if (append) begin
			ram_we = 1'b1;
		end else if (state_q == ST_SCAN) begin
			ram_wdata = ram_rdata;
			if (s1_v_s1) begin
				case (cmd_q)
					ils_pkg::CMD_INSERT: begin
						ram_we    = 1'b1;
						ram_waddr = s1_addr_s1 + AW'(1);
					end
					ils_pkg::CMD_DELETE: begin
						ram_we    = 1'b1;
						ram_waddr = s1_addr_s1 - AW'(1);
					end
					ils_pkg::CMD_REMOVE: begin
						ram_we    = !match;
						ram_waddr = wptr_q;
					end
					default: begin
						ram_we = 1'b0;
					end
				endcase
			end else if (done && (cmd_q == ils_pkg::CMD_INSERT)) begin
				ram_we    = 1'b1;
				ram_waddr = idx_q;
				ram_wdata = val_q;
			end
		end
	end

	ils_ram #(
		.WIDTH (DW),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ptr_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cmd_q         <= ils_pkg::CMD_NOP;
			res_status_q  <= ils_pkg::STS_OK;
			val_q         <= '0;
			res_data_q    <= '0;
			count_q       <= '0;
			rem_q         <= '0;
			ptr_q         <= '0;
			lim_q         <= '0;
			idx_q         <= '0;
			wptr_q        <= '0;
			pos_q         <= '0;
			rd_on_q       <= 1'b0;
			hit_q         <= 1'b0;
			s1_v_s1       <= 1'b0;
			s1_addr_s1    <= '0;
			rsp_valid     <= 1'b0;
			status        <= '0;
			data          <= '0;
			position      <= '0;
			removed_count <= '0;
			fill_count    <= '0;
			empty_res     <= 1'b0;
		end else begin
			if (rsp_ready && (state_q != ST_RESP)) begin
				rsp_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cmd_q        <= cmd_in;
						val_q        <= value;
						res_data_q   <= '0;
						rem_q        <= '0;
						wptr_q       <= '0;
						pos_q        <= '0;
						hit_q        <= 1'b0;
						case (cmd_in)
							ils_pkg::CMD_PUSH: begin
								state_q <= ST_RESP;
								if (full) begin
									res_status_q <= ils_pkg::STS_FULL;
								end else begin
									res_status_q <= ils_pkg::STS_OK;
									count_q      <= count_q + CW'(1);
								end
							end
							ils_pkg::CMD_POP: begin
								if (count_q == '0) begin
									res_status_q <= ils_pkg::STS_EMPTY;
									state_q      <= ST_RESP;
								end else begin
									res_status_q <= ils_pkg::STS_OK;
									ptr_q        <= cnt_m1[AW-1:0];
									lim_q        <= cnt_m1[AW-1:0];
									rd_on_q      <= 1'b1;
									count_q      <= cnt_m1;
									state_q      <= ST_SCAN;
								end
							end
							ils_pkg::CMD_INSERT: begin
								if (idx_x > cnt_x) begin
									res_status_q <= ils_pkg::STS_RANGE;
									state_q      <= ST_RESP;
								end else if (full) begin
									res_status_q <= ils_pkg::STS_FULL;
									state_q      <= ST_RESP;
								end else begin
									res_status_q <= ils_pkg::STS_OK;
									count_q      <= count_q + CW'(1);
									if (idx_x != cnt_x) begin
										ptr_q   <= cnt_m1[AW-1:0];
										lim_q   <= idx_x[AW-1:0];
										idx_q   <= idx_x[AW-1:0];
										rd_on_q <= 1'b1;
										state_q <= ST_SCAN;
									end else begin
										state_q <= ST_RESP;
									end
								end
							end
							ils_pkg::CMD_DELETE: begin
								if (idx_x >= cnt_x) begin
									res_status_q <= ils_pkg::STS_RANGE;
									state_q      <= ST_RESP;
								end else begin
									res_status_q <= ils_pkg::STS_OK;
									count_q      <= cnt_m1;
									if (idx_x != XW'(cnt_m1)) begin
										ptr_q   <= idx_x[AW-1:0] + AW'(1);
										lim_q   <= cnt_m1[AW-1:0];
										rd_on_q <= 1'b1;
										state_q <= ST_SCAN;
									end else begin
										state_q <= ST_RESP;
									end
								end
							end
							ils_pkg::CMD_FIND: begin
								res_status_q <= ils_pkg::STS_NOTFOUND;
								if (count_q != '0) begin
									ptr_q   <= '0;
									lim_q   <= cnt_m1[AW-1:0];
									rd_on_q <= 1'b1;
									state_q <= ST_SCAN;
								end else begin
									state_q <= ST_RESP;
								end
							end
							ils_pkg::CMD_REMOVE: begin
								res_status_q <= ils_pkg::STS_OK;
								if (count_q != '0) begin
									ptr_q   <= '0;
									lim_q   <= cnt_m1[AW-1:0];
									rd_on_q <= 1'b1;
									state_q <= ST_SCAN;
								end else begin
									state_q <= ST_RESP;
								end
							end
							ils_pkg::CMD_READ: begin
								if (idx_x >= cnt_x) begin
									res_status_q <= ils_pkg::STS_RANGE;
									state_q      <= ST_RESP;
								end else begin
									res_status_q <= ils_pkg::STS_OK;
									ptr_q        <= idx_x[AW-1:0];
									lim_q        <= idx_x[AW-1:0];
									rd_on_q      <= 1'b1;
									state_q      <= ST_SCAN;
								end
							end
							default: begin
								res_status_q <= ils_pkg::STS_OK;
								state_q      <= ST_RESP;
							end
						endcase
					end
				end
				ST_SCAN: begin
					s1_v_s1 <= rd_on_q;
					if (rd_on_q) begin
						s1_addr_s1 <= ptr_q;
						if (ptr_q == lim_q) begin
							rd_on_q <= 1'b0;
						end else if (cmd_q == ils_pkg::CMD_INSERT) begin
							ptr_q <= ptr_q - AW'(1);
						end else begin
							ptr_q <= ptr_q + AW'(1);
						end
					end
					if (s1_v_s1) begin
						case (cmd_q)
							ils_pkg::CMD_POP, ils_pkg::CMD_READ: begin
								res_data_q <= ram_rdata;
							end
							ils_pkg::CMD_FIND: begin
								if (!hit_q && match) begin
									hit_q        <= 1'b1;
									pos_q        <= s1_addr_s1;
									res_status_q <= ils_pkg::STS_OK;
								end
							end
							ils_pkg::CMD_REMOVE: begin
								if (match) begin
									rem_q <= rem_q + CW'(1);
								end else begin
									wptr_q <= wptr_q + AW'(1);
								end
							end
							default: begin
								res_data_q <= res_data_q;
							end
						endcase
					end
					if (done) begin
						if (cmd_q == ils_pkg::CMD_REMOVE) begin
							count_q <= count_q - rem_q;
						end
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (!rsp_valid || rsp_ready) begin
						rsp_valid     <= 1'b1;
						status        <= res_status_q;
						data          <= res_data_q;
						position      <= pos_x[3:0];
						removed_count <= rem_x[4:0];
						fill_count    <= cnt_nx[4:0];
						empty_res     <= (count_q == '0);
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("fill count above capacity");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) && ram_we && rd_on_q |-> ram_waddr != ptr_q)
		else $error("sweep writes the entry it is reading");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESP) && (res_status_q == ils_pkg::STS_FULL) |->
		count_q == CW'(DEPTH))
		else $error("full reported on a store with room");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESP) && (res_status_q == ils_pkg::STS_EMPTY) |->
		count_q == '0)
		else $error("empty reported on a non-empty store");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req_ready)
		else $error("second request taken while one is in progress");

endmodule

/* sv/ils_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.

module ils_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
